FILE: rtl/mexp_pkg.sv
// Package: widths, register indexes and defaults for the modular exponentiation block
`timescale 1ns / 1ps
package mexp_pkg;
    localparam int unsigned WIDTH_DEF   = 32;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 8'd1;
endpackage

FILE: rtl/modular_exponentiation.sv
// Top level: bit-serial right-to-left binary modular exponentiation
//
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes register 0
// (modulus, reset 1) or 1 (exponent, reset 0); other indexes are dropped.
// Write only while idle. Input transfer (valid/ready, base) starts one
// exponentiation; output transfer (out_valid/out_ready, power_mod,
// zero_modulus) returns one result per item.
// Sequence: a zero modulus or zero exponent goes straight to the result.
// Otherwise the base is first reduced, then per exponent bit up to the top
// set bit: one shift-and-add multiply for the square and, where the bit is
// set, one for the product, each with a set-up step, a doubling step per
// bit of its multiplier and an add step per set bit of it, through the
// single shared modular adder.
// One item at a time. A finished result sits in the output register; while
// the receiver stalls, ready stays low. Reset clears control state and sets
// the registers to their reset values.
`timescale 1ns / 1ps
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    input  logic                 valid,
    output logic                 ready,
    input  logic [WIDTH-1:0]     base,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WIDTH-1:0]     power_mod,
    output logic                 zero_modulus
);
    localparam int unsigned CW = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_NEXT, S_DONE} state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] mod_reg, exp_reg;
    logic [WIDTH-1:0] e_reg, sq_reg, acc_reg, r_reg, a_reg, b_reg, base_reg;
    logic [CW-1:0]    cnt_reg;
    logic             dbl_reg;   // 0: doubling step, 1: conditional add step
    logic             which_reg; // 0: product multiply, 1: square multiply
    logic             vout_reg, zm_reg;
    logic [WIDTH-1:0] res_reg;

    assign cfg_ready    = 1'b1;
    assign ready        = (state_reg == S_IDLE) && !vout_reg;
    assign out_valid    = vout_reg;
    assign power_mod    = res_reg;
    assign zero_modulus = zm_reg;

    // shared modular adder: (x + y) mod m for x, y < m
    logic [WIDTH-1:0] add_x, add_y, add_room, add_sum;
    always_comb
    begin
        add_x    = r_reg;
        add_y    = dbl_reg ? a_reg : r_reg;
        add_room = mod_reg - add_x;
        add_sum  = (add_y >= add_room) ? (add_y - add_room) : (add_x + add_y);
    end

    // reduction of the base: restoring, one bit per cycle
    logic [WIDTH:0]   red_sh;
    logic             red_ge;
    always_comb
    begin
        red_sh = {r_reg, base_reg[WIDTH-1]};
        red_ge = red_sh >= {1'b0, mod_reg};
    end

    logic [WIDTH-1:0] one_mod;
    assign one_mod = (mod_reg == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0 : {{(WIDTH-1){1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mod_reg   <= {{(WIDTH-1){1'b0}}, 1'b1};
            exp_reg   <= '0;
            vout_reg  <= 1'b0;
            zm_reg    <= 1'b0;
            res_reg   <= '0;
            cnt_reg   <= '0;
            dbl_reg   <= 1'b0;
            which_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_MODULUS)
                    mod_reg <= cfg_data;
                else if (cfg_index == REG_EXPONENT)
                    exp_reg <= cfg_data;
            end
            if (vout_reg && out_ready)
                vout_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (valid && ready)
                    begin
                        base_reg <= base;
                        e_reg    <= exp_reg;
                        r_reg    <= '0;
                        cnt_reg  <= CW'(WIDTH);
                        if (mod_reg == '0)
                        begin
                            res_reg <= '0;
                            zm_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else if (exp_reg == '0)
                        begin
                            res_reg <= {{(WIDTH-1){1'b0}}, 1'b1};
                            zm_reg  <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            zm_reg    <= 1'b0;
                            state_reg <= S_RED;
                        end
                    end
                end
                S_RED:
                begin
                    base_reg <= {base_reg[WIDTH-2:0], 1'b0};
                    r_reg    <= red_ge ? WIDTH'(red_sh - {1'b0, mod_reg}) : red_sh[WIDTH-1:0];
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        sq_reg  <= red_ge ? WIDTH'(red_sh - {1'b0, mod_reg})
                                          : red_sh[WIDTH-1:0];
                        acc_reg <= one_mod;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    r_reg   <= '0;
                    dbl_reg <= 1'b0;
                    cnt_reg <= CW'(WIDTH);
                    if (e_reg == '0)
                    begin
                        res_reg   <= acc_reg;
                        state_reg <= S_DONE;
                    end
                    else if (e_reg[0] && !which_reg)
                    begin
                        a_reg     <= acc_reg;
                        b_reg     <= sq_reg;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        which_reg <= 1'b1;
                        a_reg     <= sq_reg;
                        b_reg     <= sq_reg;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (!dbl_reg)
                    begin
                        r_reg   <= add_sum;
                        dbl_reg <= b_reg[WIDTH-1];
                        if (!b_reg[WIDTH-1])
                        begin
                            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
                            cnt_reg <= cnt_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        r_reg   <= add_sum;
                        dbl_reg <= 1'b0;
                        b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                    if (((!dbl_reg && !b_reg[WIDTH-1]) || dbl_reg) && cnt_reg == CW'(1))
                    begin
                        state_reg <= S_NEXT;
                        if (which_reg)
                        begin
                            sq_reg    <= add_sum;
                            which_reg <= 1'b0;
                            e_reg     <= e_reg >> 1;
                        end
                        else
                        begin
                            acc_reg   <= add_sum;
                            which_reg <= 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!vout_reg)
                    begin
                        vout_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/mexp_checker.sv
// Checker: port-level properties of the modular exponentiation block, bound to the top level
`timescale 1ns / 1ps
module mexp_checker
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             valid,
    input logic             ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] power_mod,
    input logic             zero_modulus
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_modulus |-> power_mod == '0)
        else $error("zero modulus result not zero");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ready)
        else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_mod))
        else $error("result dropped under stall");
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready |=> !ready && !out_valid)
        else $error("ready after transfer");
endmodule

bind modular_exponentiation mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

FILE: tb/sv/modular_exponentiation_tb.sv
// Testbench: modular exponentiation block against a bit-accurate predictor with random stalls
`timescale 1ns / 1ps
module modular_exponentiation_tb;
    import mexp_pkg::*;

    localparam int unsigned W = WIDTH_DEF;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [W-1:0] power_mod;
        logic         zero_modulus;
    } power_result_t;

    class power_scoreboard;
        logic [W-1:0]  modulus_reg;
        logic [W-1:0]  exponent_reg;
        power_result_t pending_powers[$];
        int            mismatches;
        int            checked;

        function new();
            modulus_reg = 1;
            exponent_reg = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] value);
            if (idx == REG_MODULUS)
                modulus_reg = value;
            else if (idx == REG_EXPONENT)
                exponent_reg = value;
        endfunction

        function logic [W-1:0] mulmod(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
            logic [2*W-1:0] prod;
            prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
            return W'(prod % {{W{1'b0}}, m});
        endfunction

        function void note_base(logic [W-1:0] base_val);
            power_result_t r;
            logic [W-1:0] sq;
            logic [W-1:0] acc;
            logic [W-1:0] e;
            r.zero_modulus = 1'b0;
            if (modulus_reg == 0)
            begin
                r.power_mod = 0;
                r.zero_modulus = 1'b1;
            end
            else if (exponent_reg == 0)
                r.power_mod = 1;
            else
            begin
                sq = base_val % modulus_reg;
                acc = (modulus_reg == 1) ? 0 : 1;
                e = exponent_reg;
                while (e != 0)
                begin
                    if (e[0])
                        acc = mulmod(acc, sq, modulus_reg);
                    sq = mulmod(sq, sq, modulus_reg);
                    e = e >> 1;
                end
                r.power_mod = acc;
            end
            pending_powers.push_back(r);
        endfunction

        function void check_power(logic [W-1:0] pm, logic zm);
            power_result_t exp_r;
            if (pending_powers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: power_mod=%h zero_modulus=%b", pm, zm);
                return;
            end
            exp_r = pending_powers.pop_front();
            checked++;
            if (exp_r.power_mod !== pm || exp_r.zero_modulus !== zm)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected power_mod=%h zero_modulus=%b, got %h %b",
                             exp_r.power_mod, exp_r.zero_modulus, pm, zm);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [W-1:0]         cfg_data;
    logic                 valid;
    logic                 ready;
    logic [W-1:0]         base;
    logic                 out_valid;
    logic                 out_ready;
    logic [W-1:0]         power_mod;
    logic                 zero_modulus;

    power_scoreboard sb;
    int  idle_cycles;
    int  sent_items;
    int  calm_send;
    int  calm_recv;
    bit  hold_recv;

    modular_exponentiation #(.WIDTH(W)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .valid(valid), .ready(ready), .base(base),
        .out_valid(out_valid), .out_ready(out_ready),
        .power_mod(power_mod), .zero_modulus(zero_modulus)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        valid = 1'b0;
        base = '0;
        out_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: random stalls, a calm stretch, and one long hold-off
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_power(power_mod, zero_modulus);
        if (rst_n)
            out_ready <= hold_recv ? 1'b0 : (calm_recv > 0) ? 1'b1 : ($urandom_range(99) >= 20);
        if (calm_recv > 0)
            calm_recv--;
    end

    initial
    begin
        hold_recv = 1'b0;
        wait (sent_items >= 150);
        hold_recv = 1'b1;
        repeat (6000) @(posedge clk);
        hold_recv = 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((valid && ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] value);
        valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_powers.size() != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_base(input logic [W-1:0] value);
        if (calm_send == 0)
            while ($urandom_range(99) < 20)
            begin
                valid <= 1'b0;
                @(posedge clk);
            end
        else
            calm_send--;
        valid <= 1'b1;
        base <= value;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        sb.note_base(value);
        sent_items++;
    endtask

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return {W{1'b1}} - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        sb = new();
        idle_cycles = 0;
        sent_items = 0;
        calm_send = 0;
        calm_recv = 0;
        @(posedge rst_n);
        // reset values: modulus 1, exponent 0
        send_base(0);
        send_base({W{1'b1}});
        write_cfg(REG_EXPONENT, {W{1'b1}});
        write_cfg(REG_MODULUS, {W{1'b1}});
        send_base({W{1'b1}});
        send_base({W{1'b1}} - 1);
        send_base(0);
        send_base(1);
        send_base(32'hAAAA5555);
        write_cfg(REG_MODULUS, 0);
        send_base(7);
        write_cfg(REG_EXPONENT, 0);
        send_base(9);
        write_cfg(REG_MODULUS, 1);
        send_base(12345);
        write_cfg(REG_EXPONENT, 65537);
        send_base(5);
        write_cfg(REG_MODULUS, 3233);
        send_base(65);
        send_base(100000);
        write_cfg(8'd7, 32'h55);
        send_base(2);
        write_cfg(REG_EXPONENT, 32'h80000000);
        write_cfg(REG_MODULUS, 32'h80000001);
        send_base(32'h7FFFFFFF);
        send_base(32'h80000001);
        for (int phase = 0; phase < 8; phase++)
        begin
            write_cfg(REG_MODULUS, (phase == 3) ? 0 : (phase == 5) ? 1 : rand_word());
            write_cfg(REG_EXPONENT, (phase == 6) ? 0 : rand_word());
            if (phase == 2)
            begin
                calm_send = 20;
                calm_recv = 40000;
            end
            for (int n = 0; n < 34; n++)
                send_base(rand_word());
        end
        valid <= 1'b0;
        while (sb.pending_powers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d bases sent, %0d results checked over several modulus and exponent settings",
                 sent_items, sb.checked);
        $display("zero modulus, zero exponent, full-width extremes and bursts with stalls covered");
        if (sb.mismatches == 0 && sb.pending_powers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
